// ----- rtl/hb_pkg.sv -----
// Package: shared types and constants of the IPv4 header builder.
`default_nettype none
package hb_pkg;

  localparam int unsigned HDR_WORDS   = 10;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 48;

  localparam logic [15:0] HDR_BYTES   = 16'd20;
  localparam logic [15:0] VER_IHL_TOS = 16'h4500;
  localparam logic [7:0]  TTL_VALUE   = 8'd64;
  localparam logic [31:0] BCAST_IP    = 32'hFFFF_FFFF;
  localparam logic [31:0] DEFAULT_GW  = 32'h0A00_0202;
  localparam logic [47:0] MAC_BCAST   = 48'hFFFF_FFFF_FFFF;

  localparam logic [CFG_IDX_W-1:0] REG_LOCAL_IP    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GATEWAY_IP  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GATEWAY_MAC = 2'd2;

  localparam logic [3:0] W_VER    = 4'd0;
  localparam logic [3:0] W_TOTLEN = 4'd1;
  localparam logic [3:0] W_ID     = 4'd2;
  localparam logic [3:0] W_FRAG   = 4'd3;
  localparam logic [3:0] W_TTL    = 4'd4;
  localparam logic [3:0] W_CSUM   = 4'd5;
  localparam logic [3:0] W_SRC_HI = 4'd6;
  localparam logic [3:0] W_SRC_LO = 4'd7;
  localparam logic [3:0] W_DST_HI = 4'd8;
  localparam logic [3:0] W_DST_LO = 4'd9;

  typedef struct packed {
    logic [31:0] dest_ip;
    logic [7:0]  proto_number;
    logic [15:0] payload_length;
  } in_t;

  typedef struct packed {
    logic [15:0] header_word;
    logic [3:0]  word_index;
    logic        last_word;
    logic [47:0] dest_mac;
    logic        arp_request;
    logic [31:0] arp_target_ip;
  } out_t;

  // One classified request waiting for the serializer.
  typedef struct packed {
    logic [15:0] tot_len;
    logic [7:0]  proto;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [16:0] csum_part;
    logic [47:0] mac;
    logic        arp;
    logic [31:0] target;
  } entry_t;

endpackage
`default_nettype wire

// ----- rtl/hb_front.sv -----
// Front end: config registers, request classification and checksum partial sum.
`default_nettype none
module hb_front (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_push,
  input  wire hb_pkg::in_t                    in_item,
  output logic                                in_ready,
  input  wire logic                           cfg_we,
  input  wire logic [hb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [hb_pkg::CFG_DATA_W-1:0]  cfg_data,
  output logic                                ent_valid,
  output hb_pkg::entry_t                      ent_data,
  input  wire logic                           ent_ready
);

  logic [31:0] local_ip_r, local_ip_nxt;
  logic [31:0] gw_ip_r, gw_ip_nxt;
  logic [47:0] gw_mac_r, gw_mac_nxt;

  logic        s1_v_r, s1_v_nxt;
  logic [15:0] s1_tot_r;
  logic [7:0]  s1_proto_r;
  logic [31:0] s1_src_r, s1_dst_r, s1_tgt_r;
  logic [16:0] s1_b_r, s1_c_r;
  logic [47:0] s1_mac_r;
  logic        s1_arp_r;

  logic           s2_v_r, s2_v_nxt;
  hb_pkg::entry_t s2_r;

  logic        s1_ready, s2_ready, accept, s1_adv;
  logic [47:0] mac_c;
  logic        arp_c;
  logic [31:0] tgt_c, gw_eff;
  logic [19:0] sum_c;

  assign s2_ready  = !s2_v_r || ent_ready;
  assign s1_ready  = !s1_v_r || s2_ready;
  assign in_ready  = s1_ready;
  assign accept    = in_push && s1_ready;
  assign s1_adv    = s1_v_r && s2_ready;
  assign ent_valid = s2_v_r;
  assign ent_data  = s2_r;

  always_comb begin
    gw_eff = (gw_ip_r[31:24] == 8'd0) ? hb_pkg::DEFAULT_GW : gw_ip_r;
    mac_c  = hb_pkg::MAC_BCAST;
    arp_c  = 1'b0;
    tgt_c  = 32'd0;
    if (in_item.dest_ip != hb_pkg::BCAST_IP) begin
      if (gw_mac_r != 48'd0) begin
        mac_c = gw_mac_r;
      end else begin
        arp_c = 1'b1;
        tgt_c = gw_eff;
      end
    end
  end

  always_comb begin
    local_ip_nxt = local_ip_r;
    gw_ip_nxt    = gw_ip_r;
    gw_mac_nxt   = gw_mac_r;
    if (cfg_we) begin
      unique case (cfg_index)
        hb_pkg::REG_LOCAL_IP:    local_ip_nxt = cfg_data[31:0];
        hb_pkg::REG_GATEWAY_IP:  gw_ip_nxt    = cfg_data[31:0];
        hb_pkg::REG_GATEWAY_MAC: gw_mac_nxt   = cfg_data;
        default: ;
      endcase
    end else if (accept && arp_c) begin
      gw_ip_nxt = gw_eff;
    end
  end

  always_comb begin
    sum_c = (20'(hb_pkg::VER_IHL_TOS) + 20'(s1_tot_r)) + (20'(s1_b_r) + 20'(s1_c_r))
            + 20'(s1_dst_r[15:0]);
  end

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (accept) begin
      s1_v_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_v_nxt = 1'b0;
    end
    s2_v_nxt = s2_v_r;
    if (s1_adv) begin
      s2_v_nxt = 1'b1;
    end else if (ent_ready) begin
      s2_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      local_ip_r <= '0;
      gw_ip_r    <= '0;
      gw_mac_r   <= '0;
      s1_v_r     <= 1'b0;
      s2_v_r     <= 1'b0;
    end else begin
      local_ip_r <= local_ip_nxt;
      gw_ip_r    <= gw_ip_nxt;
      gw_mac_r   <= gw_mac_nxt;
      s1_v_r     <= s1_v_nxt;
      s2_v_r     <= s2_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_tot_r   <= hb_pkg::HDR_BYTES + in_item.payload_length;
      s1_proto_r <= in_item.proto_number;
      s1_src_r   <= local_ip_r;
      s1_dst_r   <= in_item.dest_ip;
      s1_b_r     <= 17'({hb_pkg::TTL_VALUE, in_item.proto_number}) + 17'(local_ip_r[31:16]);
      s1_c_r     <= 17'(local_ip_r[15:0]) + 17'(in_item.dest_ip[31:16]);
      s1_mac_r   <= mac_c;
      s1_arp_r   <= arp_c;
      s1_tgt_r   <= tgt_c;
    end
    if (s1_adv) begin
      s2_r.tot_len   <= s1_tot_r;
      s2_r.proto     <= s1_proto_r;
      s2_r.src_ip    <= s1_src_r;
      s2_r.dst_ip    <= s1_dst_r;
      s2_r.csum_part <= 17'(sum_c[15:0]) + 17'(sum_c[19:16]);
      s2_r.mac       <= s1_mac_r;
      s2_r.arp       <= s1_arp_r;
      s2_r.target    <= s1_tgt_r;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/hb_queue.sv -----
// Queue of classified requests between front end and serializer.
`default_nettype none
module hb_queue #(
  parameter int unsigned DEPTH = hb_pkg::QUEUE_DEPTH
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           wr_valid,
  input  wire hb_pkg::entry_t wr_data,
  output logic                wr_ready,
  output logic                rd_valid,
  output hb_pkg::entry_t      rd_data,
  input  wire logic           rd_ready
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  hb_pkg::entry_t mem_r [DEPTH];
  logic [PTR_W-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_wr, do_rd;

  assign wr_ready = (cnt_r != FULL_CNT);
  assign rd_valid = (cnt_r != '0);
  assign rd_data  = mem_r[rp_r];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_wr) begin
      wp_nxt = (wp_r == LAST_PTR) ? '0 : wp_r + PTR_W'(1);
    end
    if (do_rd) begin
      rp_nxt = (rp_r == LAST_PTR) ? '0 : rp_r + PTR_W'(1);
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wp_r] <= wr_data;
    end
  end

`ifndef SYNTH
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= FULL_CNT)
    else $error("queue count overflow");
  a_cnt_inc: assert property (@(posedge clk) disable iff (!rst_n)
    (do_wr && !do_rd) |=> cnt_r == $past(cnt_r) + CNT_W'(1))
    else $error("queue count not incremented");
  a_cnt_dec: assert property (@(posedge clk) disable iff (!rst_n)
    (do_rd && !do_wr) |=> cnt_r == $past(cnt_r) - CNT_W'(1))
    else $error("queue count not decremented");
`endif

endmodule
`default_nettype wire

// ----- rtl/hb_back.sv -----
// Back end: final checksum fold and serialization of ten header words.
`default_nettype none
module hb_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           ent_valid,
  input  wire hb_pkg::entry_t ent_data,
  output logic                ent_ready,
  output logic                out_empty,
  output hb_pkg::out_t        out_item,
  input  wire logic           out_pop
);

  localparam logic [3:0] LAST_IDX = 4'(hb_pkg::HDR_WORDS - 1);

  logic           busy_r, busy_nxt;
  logic [3:0]     cnt_r, cnt_nxt;
  hb_pkg::entry_t cur_r;
  logic [15:0]    csum_r;
  logic           take, last, load;
  logic [15:0]    fold_c, word_c;

  assign last      = (cnt_r == LAST_IDX);
  assign take      = busy_r && out_pop;
  assign load      = ent_valid && (!busy_r || (take && last));
  assign ent_ready = load;
  assign out_empty = !busy_r;
  assign fold_c    = ent_data.csum_part[15:0] + 16'(ent_data.csum_part[16]);

  always_comb begin
    case (cnt_r)
      hb_pkg::W_VER:    word_c = hb_pkg::VER_IHL_TOS;
      hb_pkg::W_TOTLEN: word_c = cur_r.tot_len;
      hb_pkg::W_ID:     word_c = 16'd0;
      hb_pkg::W_FRAG:   word_c = 16'd0;
      hb_pkg::W_TTL:    word_c = {hb_pkg::TTL_VALUE, cur_r.proto};
      hb_pkg::W_CSUM:   word_c = csum_r;
      hb_pkg::W_SRC_HI: word_c = cur_r.src_ip[31:16];
      hb_pkg::W_SRC_LO: word_c = cur_r.src_ip[15:0];
      hb_pkg::W_DST_HI: word_c = cur_r.dst_ip[31:16];
      hb_pkg::W_DST_LO: word_c = cur_r.dst_ip[15:0];
      default:          word_c = 16'd0;
    endcase
  end

  always_comb begin
    out_item.header_word   = word_c;
    out_item.word_index    = cnt_r;
    out_item.last_word     = last;
    out_item.dest_mac      = cur_r.mac;
    out_item.arp_request   = cur_r.arp;
    out_item.arp_target_ip = cur_r.target;
  end

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    if (load) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 4'd0;
    end else if (take) begin
      if (last) begin
        busy_nxt = 1'b0;
        cnt_nxt  = 4'd0;
      end else begin
        cnt_nxt = cnt_r + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur_r  <= ent_data;
      csum_r <= ~fold_c;
    end
  end

`ifndef SYNTH
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= LAST_IDX)
    else $error("word index out of range");
  a_step: assert property (@(posedge clk) disable iff (!rst_n)
    (take && !last) |=> busy_r && cnt_r == $past(cnt_r) + 4'd1)
    else $error("word index did not advance");
  a_reload: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> busy_r && cnt_r == 4'd0)
    else $error("new item did not start at word zero");
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (take && last && !ent_valid) |=> !busy_r)
    else $error("serializer stayed busy after last word");
`endif

endmodule
`default_nettype wire

// ----- rtl/ipv4_header_builder.sv -----
// IPv4 header builder
//
// Input queue port: in_item (destination, protocol, payload length) is taken
// on a clock edge with in_push high and in_full low. Each request yields ten
// result items on the output queue port, the 16-bit header words 0..9 in
// network order, each tagged with index, last flag, destination MAC and ARP
// request/target. A result is visible while out_empty is low and is removed
// by out_pop.
// The first word of a request passes the first and second front stages, the
// queue and the serializer load, and a stall can hold it at any of these. The
// serializer emits one 16-bit word per cycle while out_pop is high.
// Up to four further requests are buffered (two front stages, two queue
// slots) while the receiver stalls; then in_full rises. Holding out_pop low
// freezes the current word on the output.
// cfg_we writes local IP (0), gateway IP (1) or gateway MAC (2); write only
// while idle. Reset (rst_n low, synchronous) clears registers and empties
// all stages.
`default_nettype none
module ipv4_header_builder #(
  parameter int unsigned QUEUE_DEPTH = hb_pkg::QUEUE_DEPTH
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_push,
  input  wire hb_pkg::in_t                    in_item,
  output logic                                in_full,
  output logic                                out_empty,
  output hb_pkg::out_t                        out_item,
  input  wire logic                           out_pop,
  input  wire logic                           cfg_we,
  input  wire logic [hb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [hb_pkg::CFG_DATA_W-1:0]  cfg_data
);

  logic           in_ready;
  logic           f_valid, f_ready, b_valid, b_ready;
  hb_pkg::entry_t f_data, b_data;

  assign in_full = !in_ready;

  hb_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_item   (in_item),
    .in_ready  (in_ready),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .ent_valid (f_valid),
    .ent_data  (f_data),
    .ent_ready (f_ready)
  );

  hb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (f_valid),
    .wr_data  (f_data),
    .wr_ready (f_ready),
    .rd_valid (b_valid),
    .rd_data  (b_data),
    .rd_ready (b_ready)
  );

  hb_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .ent_valid (b_valid),
    .ent_data  (b_data),
    .ent_ready (b_ready),
    .out_empty (out_empty),
    .out_item  (out_item),
    .out_pop   (out_pop)
  );

endmodule
`default_nettype wire

// ----- bench/ipv4_header_builder_tb.sv -----
// Self-checking testbench for ipv4_header_builder: directed table, then randomized requests.
module ipv4_header_builder_tb;

  localparam int IDLE_PCT       = 14;
  localparam int RANDOM_REQS    = 320;
  localparam int CFG_PERIOD     = 40;
  localparam int HOLD_CYCLES    = 300;
  localparam int SETTLE_CYCLES  = 6;
  localparam int TAIL_CYCLES    = 20;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam logic [hb_pkg::CFG_IDX_W-1:0] REG_NONE = 2'd3;

  typedef struct {
    bit                           is_cfg;
    logic [hb_pkg::CFG_IDX_W-1:0] idx;
    logic [47:0]                  data;
    hb_pkg::in_t                  req;
    bit                           has_golden;
    logic [15:0]                  csum;
    logic [47:0]                  mac;
    logic                         arp;
    logic [31:0]                  target;
  } step_t;

  logic                          clk       = 1'b0;
  logic                          rst_n     = 1'b0;
  logic                          in_push   = 1'b0;
  hb_pkg::in_t                   in_item   = '0;
  logic                          in_full;
  logic                          out_empty;
  hb_pkg::out_t                  out_item;
  logic                          out_pop   = 1'b0;
  logic                          cfg_we    = 1'b0;
  logic [hb_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [hb_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

  // predictor copy of the registers
  logic [31:0] local_ip_q;
  logic [31:0] gateway_ip_q;
  logic [47:0] gateway_mac_q;

  hb_pkg::out_t pending_words[$];
  int   errors    = 0;
  bit   quiet     = 1'b0;
  bit   want_hold = 1'b0;
  bit   hold_done = 1'b0;
  int   hold_left = 0;
  int   stuck;

  ipv4_header_builder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_item   (in_item),
    .in_full   (in_full),
    .out_empty (out_empty),
    .out_item  (out_item),
    .out_pop   (out_pop),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    $display("mismatch %s: got %0h want %0h", what, got, want);
    errors++;
  endtask

  // expected header words for one request; may retarget the gateway
  task automatic build_header(input hb_pkg::in_t req);
    logic [15:0]  w [hb_pkg::HDR_WORDS];
    logic [31:0]  acc;
    logic [47:0]  mac;
    logic         arp;
    logic [31:0]  target;
    hb_pkg::out_t o;
    int           i;
    w[hb_pkg::W_VER]    = hb_pkg::VER_IHL_TOS;
    w[hb_pkg::W_TOTLEN] = hb_pkg::HDR_BYTES + req.payload_length;
    w[hb_pkg::W_ID]     = '0;
    w[hb_pkg::W_FRAG]   = '0;
    w[hb_pkg::W_TTL]    = {hb_pkg::TTL_VALUE, req.proto_number};
    w[hb_pkg::W_CSUM]   = '0;
    w[hb_pkg::W_SRC_HI] = local_ip_q[31:16];
    w[hb_pkg::W_SRC_LO] = local_ip_q[15:0];
    w[hb_pkg::W_DST_HI] = req.dest_ip[31:16];
    w[hb_pkg::W_DST_LO] = req.dest_ip[15:0];
    acc = '0;
    for (i = 0; i < hb_pkg::HDR_WORDS; i++) acc = acc + 32'(w[i]);
    while (acc[31:16] != 16'd0) acc = 32'(acc[15:0]) + 32'(acc[31:16]);
    w[hb_pkg::W_CSUM] = ~acc[15:0];
    mac    = hb_pkg::MAC_BCAST;
    arp    = 1'b0;
    target = '0;
    if (req.dest_ip != hb_pkg::BCAST_IP) begin
      if (gateway_mac_q != '0) begin
        mac = gateway_mac_q;
      end else begin
        if (gateway_ip_q[31:24] == 8'd0) gateway_ip_q = hb_pkg::DEFAULT_GW;
        arp    = 1'b1;
        target = gateway_ip_q;
      end
    end
    for (i = 0; i < hb_pkg::HDR_WORDS; i++) begin
      o.header_word   = w[i];
      o.word_index    = i[3:0];
      o.last_word     = (i == hb_pkg::HDR_WORDS - 1);
      o.dest_mac      = mac;
      o.arp_request   = arp;
      o.arp_target_ip = target;
      pending_words.push_back(o);
    end
  endtask

  task automatic offer_request(input hb_pkg::in_t req);
    if (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
      in_push <= 1'b0;
      do @(posedge clk); while (!quiet && $urandom_range(0, 99) < IDLE_PCT);
    end
    in_push <= 1'b1;
    in_item <= req;
    do @(posedge clk); while (in_full);
    build_header(req);
  endtask

  task automatic settle();
    in_push <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [hb_pkg::CFG_IDX_W-1:0] idx, input logic [47:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      hb_pkg::REG_LOCAL_IP:    local_ip_q    = data[31:0];
      hb_pkg::REG_GATEWAY_IP:  gateway_ip_q  = data[31:0];
      hb_pkg::REG_GATEWAY_MAC: gateway_mac_q = data[47:0];
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] pick_ip();
    case ($urandom_range(0, 5))
      0:       return 32'h0;
      1:       return 32'hFFFF_FFFF;
      2:       return {8'h00, 24'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  function automatic step_t cfg_row(input logic [hb_pkg::CFG_IDX_W-1:0] idx,
                                    input logic [47:0] data);
    step_t s;
    s = '{default: '0};
    s.is_cfg = 1'b1;
    s.idx    = idx;
    s.data   = data;
    return s;
  endfunction

  function automatic step_t req_row(input logic [31:0] dst, input logic [7:0] proto,
                                    input logic [15:0] plen);
    step_t s;
    s = '{default: '0};
    s.req.dest_ip        = dst;
    s.req.proto_number   = proto;
    s.req.payload_length = plen;
    return s;
  endfunction

  function automatic step_t golden_row(input logic [31:0] dst, input logic [7:0] proto,
                                       input logic [15:0] plen, input logic [15:0] csum,
                                       input logic [47:0] mac, input logic arp,
                                       input logic [31:0] target);
    step_t s;
    s = req_row(dst, proto, plen);
    s.has_golden = 1'b1;
    s.csum       = csum;
    s.mac        = mac;
    s.arp        = arp;
    s.target     = target;
    return s;
  endfunction

  // result side: check, then decide pop for the next cycle
  always @(posedge clk) begin
    hb_pkg::out_t want;
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) begin
        if (pending_words.size() == 0) begin
          flag_mismatch("unexpected item", 64'(out_item.header_word), '0);
        end else begin
          want = pending_words.pop_front();
          if (out_item.header_word != want.header_word)
            flag_mismatch("header_word", 64'(out_item.header_word),
                          64'(want.header_word));
          if (out_item.word_index != want.word_index)
            flag_mismatch("word_index", 64'(out_item.word_index), 64'(want.word_index));
          if (out_item.last_word != want.last_word)
            flag_mismatch("last_word", 64'(out_item.last_word), 64'(want.last_word));
          if (out_item.dest_mac != want.dest_mac)
            flag_mismatch("dest_mac", 64'(out_item.dest_mac), 64'(want.dest_mac));
          if (out_item.arp_request != want.arp_request)
            flag_mismatch("arp_request", 64'(out_item.arp_request),
                          64'(want.arp_request));
          if (out_item.arp_target_ip != want.arp_target_ip)
            flag_mismatch("arp_target_ip", 64'(out_item.arp_target_ip),
                          64'(want.arp_target_ip));
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_pop <= 1'b0;
      end else if (want_hold && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
        out_pop   <= 1'b0;
      end else begin
        out_pop <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  initial begin
    stuck = 0;
    @(posedge rst_n);
    while (stuck < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_push && !in_full) || (out_pop && !out_empty)) stuck = 0;
      else stuck++;
    end
    $display("ipv4_header_builder regression: fail");
    $finish;
  end

  initial begin
    step_t       plan[$];
    hb_pkg::in_t req;
    int          n;
    int          k;
    int          base;

    local_ip_q    = '0;
    gateway_ip_q  = '0;
    gateway_mac_q = '0;

    // after reset: unresolved gateway falls back to the default router
    plan.push_back(golden_row(32'h0000_0000, 8'h00, 16'h0000, 16'h7AEB, hb_pkg::MAC_BCAST,
                              1'b1, hb_pkg::DEFAULT_GW));
    // broadcast, total length wraps
    plan.push_back(golden_row(32'hFFFF_FFFF, 8'hFF, 16'hFFFF, 16'h79ED, hb_pkg::MAC_BCAST,
                              1'b0, 32'h0));
    plan.push_back(cfg_row(hb_pkg::REG_LOCAL_IP, 48'hFFFF_FFFF_FFFF));
    plan.push_back(cfg_row(hb_pkg::REG_GATEWAY_MAC, 48'h0123_4567_89AB));
    plan.push_back(cfg_row(REG_NONE, 48'hFFFF_FFFF_FFFF));
    plan.push_back(golden_row(32'h0102_0304, 8'h06, 16'h0000, 16'h76DF, 48'h0123_4567_89AB,
                              1'b0, 32'h0));
    plan.push_back(req_row(32'hFFFF_FFFF, 8'h11, 16'h0000));
    plan.push_back(cfg_row(hb_pkg::REG_GATEWAY_MAC, 48'h0));
    plan.push_back(cfg_row(hb_pkg::REG_GATEWAY_IP, 48'h00FF_FFFF));
    plan.push_back(req_row(32'h7FFF_FFFF, 8'h01, 16'd65515));
    plan.push_back(cfg_row(hb_pkg::REG_GATEWAY_IP, 48'hC0A8_0001));
    plan.push_back(req_row(32'hFFFF_FFFE, 8'h80, 16'd65516));
    plan.push_back(req_row(32'h8000_0000, 8'h7F, 16'd1));
    plan.push_back(cfg_row(hb_pkg::REG_GATEWAY_MAC, 48'hFFFF_FFFF_FFFF));
    plan.push_back(req_row(32'h0A00_0001, 8'h11, 16'd1480));
    plan.push_back(cfg_row(hb_pkg::REG_GATEWAY_IP, 48'hFFFF_FFFF_FFFF));
    plan.push_back(cfg_row(hb_pkg::REG_LOCAL_IP, 48'h0));
    plan.push_back(cfg_row(hb_pkg::REG_GATEWAY_MAC, 48'h0));
    plan.push_back(req_row(32'h0000_0001, 8'h01, 16'd8000));
    plan.push_back(req_row(32'hFFFF_FFFF, 8'h00, 16'h0000));

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[r]) begin
      if (plan[r].is_cfg) begin
        settle();
        write_reg(plan[r].idx, plan[r].data);
      end else begin
        offer_request(plan[r].req);
        if (plan[r].has_golden) begin
          base = int'(pending_words.size()) - int'(hb_pkg::HDR_WORDS);
          for (k = 0; k < int'(hb_pkg::HDR_WORDS); k++) begin
            if (k == int'(hb_pkg::W_CSUM)) pending_words[base + k].header_word = plan[r].csum;
            pending_words[base + k].dest_mac      = plan[r].mac;
            pending_words[base + k].arp_request   = plan[r].arp;
            pending_words[base + k].arp_target_ip = plan[r].target;
          end
        end
      end
    end

    for (n = 0; n < RANDOM_REQS; n++) begin
      if (n % CFG_PERIOD == 0) begin
        settle();
        write_reg(hb_pkg::REG_LOCAL_IP, {16'($urandom), pick_ip()});
        write_reg(hb_pkg::REG_GATEWAY_IP, {16'($urandom), pick_ip()});
        case ($urandom_range(0, 5))
          0, 1:    write_reg(hb_pkg::REG_GATEWAY_MAC, 48'h0);
          2:       write_reg(hb_pkg::REG_GATEWAY_MAC, hb_pkg::MAC_BCAST);
          default: write_reg(hb_pkg::REG_GATEWAY_MAC, {16'($urandom), 32'($urandom)});
        endcase
        if ($urandom_range(0, 3) == 0) write_reg(REG_NONE, {16'($urandom), 32'($urandom)});
      end
      quiet = (n >= 150 && n < 230);
      if (n == 60) want_hold = 1'b1;
      req.dest_ip      = ($urandom_range(0, 7) == 0) ? hb_pkg::BCAST_IP : 32'($urandom);
      req.proto_number = 8'($urandom_range(0, 255));
      case ($urandom_range(0, 19))
        0:       req.payload_length = 16'($urandom_range(0, 65535));
        1:       req.payload_length = 16'($urandom_range(65515, 65535));
        default: req.payload_length = 16'($urandom_range(0, 1500));
      endcase
      offer_request(req);
    end

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("ipv4_header_builder regression: pass");
    else
      $display("ipv4_header_builder regression: fail");
    $finish;
  end

endmodule
